FILE: rtl/core/function_range_trace_buffer_assert.svh
// assertion macros shared by the function range trace buffer rtl
// depends on nothing; included by the files that check their own logic
`ifndef FUNCTION_RANGE_TRACE_BUFFER_ASSERT_SVH
`define FUNCTION_RANGE_TRACE_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds at every edge outside reset
`define FRTB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("frtb check failed");

// consequent holds in the same cycle as the antecedent
`define FRTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frtb check failed");

// consequent holds in the cycle after the antecedent
`define FRTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frtb check failed");

`else

`define FRTB_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FRTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FRTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/frtb_pkg.sv
// shared types and codes of the function range trace buffer
// depends on nothing; used by the controller, datapath and top level
package frtb_pkg;

  localparam int PC_W  = 64;
  localparam int IDX_W = 12;

  // item function codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_DUMP = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LOAD_ACK = 2'd0;
  localparam logic [1:0] KIND_STEP_REP = 2'd1;
  localparam logic [1:0] KIND_RING_ENT = 2'd2;

  // table index meaning user code (no match)
  localparam logic [IDX_W-1:0] USER_INDEX = {IDX_W{1'b1}};

  typedef struct packed {
    logic [1:0]      func;
    logic [PC_W-1:0] pc;
    logic [PC_W-1:0] range_start;
    logic [PC_W-1:0] range_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    table_full;
    logic [PC_W-1:0]         entry_pc;
    logic signed [IDX_W-1:0] func_index;
    logic                    recorded;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic trace_enable;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_commit;
    logic scan_start;
    logic scan_run;
    logic step_commit;
    logic dump_start;
    logic dump_read;
    logic dump_emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enable;
    logic scan_done;
    logic out_free;
    logic dump_last;
  } dp_sts_t;

endpackage

FILE: rtl/core/frtb_chan_if.sv
// valid/ready channel carrying one item of a given payload type
// depends on nothing; payload types come from frtb_pkg at the instance
interface frtb_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/frtb_ctrl.sv
// controller state machine of the function range trace buffer
// depends on frtb_pkg and the assertion macro header
`include "function_range_trace_buffer_assert.svh"

module frtb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_func,
  output logic                  in_ready,
  output frtb_pkg::ctrl_cmd_t   cmd,
  input  frtb_pkg::dp_sts_t     sts
);
  import frtb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_STEP,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (sts.enable) begin
            case (in_func)
              FUNC_LOAD: begin
                state_nxt = ST_LOAD;
              end
              FUNC_STEP: begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_SCAN;
              end
              FUNC_DUMP: begin
                cmd.dump_start = 1'b1;
                state_nxt      = ST_DUMP_RD;
              end
              default: begin
                state_nxt = ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.out_free) begin
          cmd.step_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        cmd.dump_read = 1'b1;
        state_nxt     = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.dump_emit = 1'b1;
          state_nxt     = sts.dump_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a result is only pushed when the output register has room
  `FRTB_ASSERT_IMP(a_commit_room, clk, rst_n,
    cmd.load_commit || cmd.step_commit || cmd.dump_emit, sts.out_free)
  // at most one result source per cycle
  `FRTB_ASSERT_ALWAYS(a_one_commit, clk, rst_n,
    (2'(cmd.load_commit) + 2'(cmd.step_commit) + 2'(cmd.dump_emit)) <= 2'd1)
  // a started scan holds off further items
  `FRTB_ASSERT_NXT(a_scan_busy, clk, rst_n, cmd.scan_start, !in_ready)

endmodule

FILE: rtl/core/frtb_dp.sv
// datapath of the function range trace buffer: range table memory, scan
// pipeline, trace ring and output register; depends on frtb_pkg and the macro header
`include "function_range_trace_buffer_assert.svh"

module frtb_dp #(
  parameter int TABLE_DEPTH = 2048,
  parameter int RING_DEPTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  frtb_pkg::in_item_t    in_data,
  input  logic                  cfg_we,
  input  frtb_pkg::cfg_item_t   cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output frtb_pkg::out_item_t   out_data,
  input  frtb_pkg::ctrl_cmd_t   cmd,
  output frtb_pkg::dp_sts_t     sts
);
  import frtb_pkg::*;

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam logic [CNT_W-1:0]   TABLE_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [RING_AW-1:0] RING_LAST  = RING_AW'(RING_DEPTH - 1);

  typedef struct packed {
    logic [PC_W-1:0] start;
    logic [PC_W-1:0] size;
  } range_ent_t;

  typedef struct packed {
    logic [PC_W-1:0]  pc;
    logic [IDX_W-1:0] idx;
  } ring_ent_t;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
    return (p == RING_LAST) ? '0 : p + 1'b1;
  endfunction

  logic                 enable_r;
  logic [PC_W-1:0]      pc_r, rstart_r, rsize_r;
  logic [CNT_W-1:0]     count_r;
  logic                 tbl_full;
  range_ent_t           tbl_mem [TABLE_DEPTH];
  range_ent_t           tbl_rd_r;
  logic [CNT_W-1:0]     scan_idx_r;
  logic                 scan_issue;
  logic                 s1_v_r, s2_v_r;
  logic [ADDR_W-1:0]    s1_idx_r, s2_idx_r;
  logic [PC_W-1:0]      s2_start_r, s2_end_r;
  logic                 s2_hit;
  logic [IDX_W-1:0]     match_r;
  logic [IDX_W-1:0]     newest_r;
  logic [RING_AW-1:0]   wp_r;
  logic                 rec;
  ring_ent_t            ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_r;
  ring_ent_t            ring_rd_r;
  logic [RING_AW-1:0]   dump_ptr_r, dump_k_r;
  logic                 out_free;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_data.trace_enable;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pc_r     <= in_data.pc;
      rstart_r <= in_data.range_start;
      rsize_r  <= in_data.range_size;
    end
  end

  // table fill count
  assign tbl_full = (count_r == TABLE_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load_commit && !tbl_full) begin
      count_r <= count_r + 1'b1;
    end
  end

  // range table memory: one write port for loads, one read port for the scan
  assign scan_issue = cmd.scan_run && (scan_idx_r < count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_commit && !tbl_full) begin
      tbl_mem[count_r[ADDR_W-1:0]] <= '{start: rstart_r, size: rsize_r};
    end
    if (scan_issue) begin
      tbl_rd_r <= tbl_mem[scan_idx_r[ADDR_W-1:0]];
    end
  end

  // scan address and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
      end else if (scan_issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      s1_v_r <= scan_issue;
      s2_v_r <= s1_v_r;
    end
  end

  // end of range computed a stage ahead of the compare
  always_ff @(posedge clk) begin
    s1_idx_r   <= scan_idx_r[ADDR_W-1:0];
    s2_idx_r   <= s1_idx_r;
    s2_start_r <= tbl_rd_r.start;
    s2_end_r   <= tbl_rd_r.start + tbl_rd_r.size;
  end

  // last matching range wins
  assign s2_hit = s2_v_r && (pc_r >= s2_start_r) && (pc_r <= s2_end_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      match_r <= USER_INDEX;
    end else if (s2_hit) begin
      match_r <= IDX_W'(s2_idx_r);
    end
  end

  // ring bookkeeping
  assign rec = (match_r != newest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      newest_r   <= '0;
      ring_vld_r <= '0;
    end else if (cmd.step_commit && rec) begin
      wp_r             <= ring_next(wp_r);
      newest_r         <= match_r;
      ring_vld_r[wp_r] <= 1'b1;
    end
  end

  // ring memory; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (cmd.step_commit && rec) begin
      ring_mem[wp_r] <= '{pc: (match_r == USER_INDEX) ? '0 : pc_r, idx: match_r};
    end
    if (cmd.dump_read) begin
      ring_rd_r <= ring_vld_r[dump_ptr_r] ? ring_mem[dump_ptr_r] : '0;
    end
  end

  // dump walk, oldest entry first
  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      dump_ptr_r <= wp_r;
      dump_k_r   <= '0;
    end else if (cmd.dump_emit) begin
      dump_ptr_r <= ring_next(dump_ptr_r);
      dump_k_r   <= dump_k_r + 1'b1;
    end
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_commit || cmd.step_commit || cmd.dump_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_commit) begin
      out_data_r.kind       <= KIND_LOAD_ACK;
      out_data_r.table_full <= tbl_full;
      out_data_r.entry_pc   <= '0;
      out_data_r.func_index <= tbl_full ? USER_INDEX : IDX_W'(count_r);
      out_data_r.recorded   <= 1'b0;
      out_data_r.last       <= 1'b1;
    end else if (cmd.step_commit) begin
      out_data_r.kind       <= KIND_STEP_REP;
      out_data_r.table_full <= 1'b0;
      out_data_r.entry_pc   <= pc_r;
      out_data_r.func_index <= match_r;
      out_data_r.recorded   <= rec;
      out_data_r.last       <= 1'b1;
    end else if (cmd.dump_emit) begin
      out_data_r.kind       <= KIND_RING_ENT;
      out_data_r.table_full <= 1'b0;
      out_data_r.entry_pc   <= ring_rd_r.pc;
      out_data_r.func_index <= ring_rd_r.idx;
      out_data_r.recorded   <= 1'b0;
      out_data_r.last       <= (dump_k_r == RING_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the controller
  assign sts.enable    = enable_r;
  assign sts.scan_done = (scan_idx_r == count_r) && !s1_v_r && !s2_v_r;
  assign sts.out_free  = out_free;
  assign sts.dump_last = (dump_k_r == RING_LAST);

  // fill count never passes the table size
  `FRTB_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= TABLE_FULL)
  // only loaded entries reach the compare stage
  `FRTB_ASSERT_IMP(a_scan_loaded, clk, rst_n, s2_v_r, CNT_W'(s2_idx_r) < count_r)
  // a recorded step makes its match the newest ring index
  `FRTB_ASSERT_NXT(a_newest_track, clk, rst_n, cmd.step_commit && rec,
    newest_r == $past(match_r))

endmodule

FILE: rtl/core/function_range_trace_buffer.sv
// top level of the function range trace buffer
// depends on frtb_pkg, frtb_chan_if, frtb_ctrl and frtb_dp
//
// Keeps a table of function address ranges and a ring of recent trace
// entries. Items are taken one at a time; in_chan.ready is high only while
// no item is in progress, and a finished result waits in the output register
// while the next item is taken. A disabled or unknown item gives no result.
// A step reads one range per cycle through the single read port of the
// range table memory, over every range loaded. A dump reads the ring memory
// once per entry and emits each entry before it reads the next. No clearing
// pass runs after reset: ring entries carry valid bits and read as zero
// until written.
module function_range_trace_buffer #(
  parameter int TABLE_DEPTH = 2048,
  parameter int RING_DEPTH  = 16
) (
  input logic         clk,
  input logic         rst_n,
  frtb_chan_if.sink   in_chan,
  frtb_chan_if.source out_chan,
  frtb_chan_if.sink   cfg_chan
);
  import frtb_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // the single register is always writable
  assign cfg_chan.ready = 1'b1;

  // sequencing
  frtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.data.func),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // storage, scan and result register
  frtb_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RING_DEPTH  (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_chan.data),
    .cfg_we    (cfg_chan.valid),
    .cfg_data  (cfg_chan.data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
